/* sv/phmd_pkg.sv */
// phmd_pkg: shared types and constants for the polynomial hash block
// no dependencies; imported by phmd_rem_unit and polynomial_hash_mod_divisor
package phmd_pkg;

	localparam int unsigned DATA_W     = 32;
	localparam int unsigned DIVIDEND_W = 38;
	localparam int unsigned STEP_CNT_W = $clog2(DIVIDEND_W);

	localparam logic [DATA_W-1:0] HASH_MULT     = 32'd31;
	localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd1000003;

	typedef logic [DATA_W-1:0]     data_t;
	typedef logic [DIVIDEND_W-1:0] dividend_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} phmd_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} phmd_div_status_t;

endpackage

/* sv/phmd_rem_unit.sv */
// phmd_rem_unit: radix-2 restoring remainder unit, one quotient bit per cycle
// depends on phmd_pkg
module phmd_rem_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  phmd_pkg::dividend_t       dividend,
	input  phmd_pkg::data_t           divisor,
	output phmd_pkg::data_t           remainder,
	output phmd_pkg::phmd_div_status_t status
);
	import phmd_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	dividend_t             dvd_q;
	data_t                 rem_q;

	logic [DATA_W:0] shifted;
	logic [DATA_W:0] trial;
	logic            fits;

	// shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		shifted = {rem_q, dvd_q[DIVIDEND_W-1]};
		trial   = shifted - {1'b0, divisor};
		fits    = (shifted >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

/* sv/polynomial_hash_mod_divisor.sv */
// polynomial_hash_mod_divisor: hash = (h*31 + value) mod modulus, one result per transaction
// the 38 single-bit steps of the shared remainder unit (phmd_rem_unit) run per item;
// in_stall stays high until the result is loaded, so one input transaction at a time
// reset: asynchronous active-low arst_n clears running hash to 0, modulus to 1000003
// depends on phmd_pkg and phmd_rem_unit
module polynomial_hash_mod_divisor (
	input  logic            clk,
	input  logic            arst_n,
	// input channel
	input  logic            in_valid,
	output logic            in_stall,
	input  phmd_pkg::data_t value,
	input  phmd_pkg::data_t seed,
	input  logic            first,
	input  logic            last,
	// result channel
	output logic            out_valid,
	input  logic            out_stall,
	output phmd_pkg::data_t hash,
	output logic            last_res,
	// modulus write channel
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  phmd_pkg::data_t modulus
);
	import phmd_pkg::*;

	phmd_state_t state_q;
	phmd_state_t state_d;

	data_t       modulus_q;
	data_t       running_hash_q;

	// captured input transaction
	data_t       value_q;
	data_t       seed_q;
	logic        first_q;
	logic        last_q;

	// h*31 + value, held for the zero-modulus result
	dividend_t   sum_s1;

	// output register
	logic        out_valid_q;
	data_t       hash_q;
	logic        last_res_q;

	logic             in_take;
	logic             out_free;
	logic             div_start;
	logic             load_out;
	data_t            h_sel;
	dividend_t        sum_d;
	data_t            rem;
	data_t            result;
	phmd_div_status_t div_status;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// h*31 done as (h<<5) - h, no multiplier needed
	always_comb begin
		h_sel = first_q ? seed_q : running_hash_q;
		sum_d = {1'b0, h_sel, 5'b0} - {6'b0, h_sel} + {6'b0, value_q};
	end

	// zero modulus stands for 2^32: keep the low word of the sum
	assign result = (modulus_q == '0) ? sum_s1[DATA_W-1:0] : rem;

	// divider loads the sum in the same cycle that sum_s1 does
	phmd_rem_unit u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (sum_d),
		.divisor   (modulus_q),
		.remainder (rem),
		.status    (div_status)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_status.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
			end
			ST_SUM: begin
				div_start = 1'b1;
			end
			ST_DIV: begin
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			modulus_q      <= MODULUS_RESET;
			running_hash_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) modulus_q <= modulus;
			if (load_out) begin
				running_hash_q <= result;
				out_valid_q    <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			value_q <= value;
			seed_q  <= seed;
			first_q <= first;
			last_q  <= last;
		end
		if (state_q == ST_SUM) sum_s1 <= sum_d;
		if (load_out) begin
			hash_q     <= result;
			last_res_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;
	assign last_res  = last_res_q;

endmodule
